@@ rtl/core/csa_pkg.sv @@
// ---------------------------------------------------------------------------
// csa_pkg: shared types and constants of the crc hashed slot allocator
// holds the controller states, the crc nibble step and the salt constants
// ---------------------------------------------------------------------------
package csa_pkg;

    // reflected crc-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // salt low byte counts 0..254, then wraps with a carry into the high byte
    localparam logic [7:0]  SALT_LOW_LAST = 8'd254;
    // last try number of one salt period (65280 tries)
    localparam logic [15:0] TRY_LAST = 16'd65279;

    // register map, word index taken from paddr[2]
    localparam logic REG_SLOT_COUNT = 1'b0;
    localparam logic [12:0] SLOT_COUNT_RST = 13'd4096;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_COUNT = 9'b000000010,
        ST_IDLE  = 9'b000000100,
        ST_PRE   = 9'b000001000,
        ST_SALT  = 9'b000010000,
        ST_MOD   = 9'b000100000,
        ST_READ  = 9'b001000000,
        ST_CHECK = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    // one nibble of the reflected crc, lowest message bits first
    function automatic logic [31:0] crc_nib(input logic [31:0] c, input logic [3:0] d);
        logic [31:0] t;
        t = c ^ {28'b0, d};
        for (int k = 0; k < 4; k++) begin
            t = (t >> 1) ^ (t[0] ? CRC_POLY : 32'h0);
        end
        return t;
    endfunction

endpackage

@@ rtl/core/csa_ram.sv @@
// ---------------------------------------------------------------------------
// csa_ram: generic single write port, single read port ram
// read data is registered, valid in the cycle after the address
// ---------------------------------------------------------------------------
module csa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/crc_hashed_slot_allocator.sv @@
// ---------------------------------------------------------------------------
// crc_hashed_slot_allocator: claims a free slot picked by a salted crc hash
// top level with stream channels, apb register port and the used-slot map
// ---------------------------------------------------------------------------
// usage
//   input beat on s_axis: tdata = {entry_index, app_id}; one result beat on
//   m_axis per request: tdata = slot (zero padded), tuser = full flag
//   apb register 0 (byte address 0) is slot_count, the hash modulus
// hashing
//   the crc of the id and index bytes runs a nibble per cycle, then every
//   try hashes the two salt bytes, reduces the hash by a bit-serial
//   remainder and probes the map, a read and then a check of the entry
//   a map with no free slot below slot_count answers full without a search
// reset
//   a clearing pass writes every map entry free before the first beat is
//   taken; a slot_count write while idle or recounting starts a recount of
//   used slots below the effective count, and no beat is taken meanwhile
// stall
//   a finished result waits in the output register; a new request is taken
//   meanwhile and its result holds until the output register frees
// ---------------------------------------------------------------------------
module crc_hashed_slot_allocator
    import csa_pkg::*;
#(
    parameter int SLOTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] app_id, [31:16] entry_index
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] slot, [15:12] zero
    output logic        m_axis_tuser,   // [0] full_res
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (CW > 12) ? CW : 12;

    t_state r_state, n_state;

    // control state
    logic [CW-1:0] r_scan, n_scan;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_cnt, n_cnt;          // used slots below the slot count
    logic [12:0]   r_slot_count, n_slot_count;
    logic [2:0]    r_dig, n_dig;
    logic [3:0]    r_bit, n_bit;
    logic [15:0]   r_tries, n_tries;
    logic          r_out_vld, n_out_vld;

    // datapath
    logic [31:0]   r_sh, n_sh;            // message digit shift register
    logic [31:0]   r_crc, n_crc;
    logic [31:0]   r_base, n_base;        // crc after the four fixed bytes
    logic [15:0]   r_div, n_div;          // hash bits, msb first into remainder
    logic [CW-1:0] r_rem, n_rem;
    logic [15:0]   r_salt, n_salt;
    logic [11:0]   r_res_slot, n_res_slot;
    logic          r_res_full, n_res_full;
    logic [11:0]   r_out_slot, n_out_slot;
    logic          r_out_full, n_out_full;

    // map port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;

    logic [CW-1:0] n_eff;
    logic [31:0]   crc_next;
    logic [CW:0]   rem2;
    logic [CW-1:0] rem_red;
    logic [SW-1:0] slot_ext;
    logic [15:0]   salt_step;
    logic          cfg_wr;
    logic          scan_issue;
    logic          in_acc;

    // effective slot count: zero counts as one, capped at SLOTS
    always_comb begin
        if (r_slot_count == 13'd0) begin
            n_eff = CW'(1);
        end else if (32'(r_slot_count) > SLOTS) begin
            n_eff = CW'(SLOTS);
        end else begin
            n_eff = CW'(r_slot_count);
        end
    end

    assign crc_next = crc_nib(r_crc, r_sh[3:0]);

    // one restoring remainder step
    assign rem2    = {r_rem, r_div[15]};
    assign rem_red = (rem2 >= {1'b0, n_eff}) ? CW'(rem2 - {1'b0, n_eff}) : CW'(rem2);

    assign slot_ext = SW'(r_rem);

    // salt low byte wraps after 254 with a carry into the high byte
    assign salt_step = (r_salt[7:0] == SALT_LOW_LAST) ?
                       {r_salt[15:8] + 8'd1, 8'd0} : {r_salt[15:8], r_salt[7:0] + 8'd1};

    assign cfg_wr     = psel && penable && pwrite && pready;
    assign scan_issue = (r_scan < n_eff);
    assign in_acc     = s_axis_tvalid && s_axis_tready;

    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_SLOT_COUNT) ? {19'b0, r_slot_count} : 32'b0;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0, r_out_slot};
    assign m_axis_tuser  = r_out_full;

    // map write side: zeros during the clearing pass, a mark on allocation
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_scan[AW-1:0];
        mem_wdata = 1'b0;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == ST_CHECK && !mem_rdata) begin
            mem_we    = 1'b1;
            mem_waddr = r_rem[AW-1:0];
            mem_wdata = 1'b1;
        end
    end

    assign mem_raddr = (r_state == ST_COUNT) ? r_scan[AW-1:0] : r_rem[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_pend       = 1'b0;
        n_cnt        = r_cnt;
        n_slot_count = r_slot_count;
        n_dig        = r_dig;
        n_bit        = r_bit;
        n_tries      = r_tries;
        n_out_vld    = r_out_vld;
        n_sh         = r_sh;
        n_crc        = r_crc;
        n_base       = r_base;
        n_div        = r_div;
        n_rem        = r_rem;
        n_salt       = r_salt;
        n_res_slot   = r_res_slot;
        n_res_full   = r_res_full;
        n_out_slot   = r_out_slot;
        n_out_full   = r_out_full;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                n_scan = r_scan + CW'(1);
                if (r_scan == CW'(SLOTS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_COUNT: begin
                if (scan_issue) begin
                    n_scan = r_scan + CW'(1);
                end
                n_pend = scan_issue;
                if (r_pend && mem_rdata) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (!scan_issue && !r_pend) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_sh    = s_axis_tdata;
                    n_crc   = CRC_INIT;
                    n_dig   = '0;
                    n_salt  = '0;
                    n_tries = '0;
                    if (r_cnt >= n_eff) begin
                        // no free slot below the count
                        n_res_slot = '0;
                        n_res_full = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_PRE;
                    end
                end
            end
            ST_PRE: begin
                n_crc = crc_next;
                n_sh  = r_sh >> 4;
                n_dig = r_dig + 3'd1;
                if (r_dig == 3'd7) begin
                    n_base  = crc_next;
                    n_sh    = {16'b0, r_salt};
                    n_dig   = '0;
                    n_state = ST_SALT;
                end
            end
            ST_SALT: begin
                n_crc = crc_next;
                n_sh  = r_sh >> 4;
                n_dig = r_dig + 3'd1;
                if (r_dig == 3'd3) begin
                    n_div   = ~crc_next[15:0];
                    n_rem   = '0;
                    n_bit   = '0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                n_rem = rem_red;
                n_div = r_div << 1;
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!mem_rdata) begin
                    n_cnt      = r_cnt + CW'(1);
                    n_res_slot = slot_ext[11:0];
                    n_res_full = 1'b0;
                    n_state    = ST_DONE;
                end else if (r_tries == TRY_LAST) begin
                    // salt period exhausted
                    n_res_slot = '0;
                    n_res_full = 1'b1;
                    n_state    = ST_DONE;
                end else begin
                    n_tries = r_tries + 16'd1;
                    n_salt  = salt_step;
                    n_sh    = {16'b0, salt_step};
                    n_crc   = r_base;
                    n_dig   = '0;
                    n_state = ST_SALT;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_slot = r_res_slot;
                    n_out_full = r_res_full;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register write; a new count restarts the used-slot recount when idle or counting
        if (cfg_wr && paddr[2] == REG_SLOT_COUNT) begin
            n_slot_count = pwdata[12:0];
            if (r_state == ST_IDLE || r_state == ST_COUNT) begin
                n_scan  = '0;
                n_pend  = 1'b0;
                n_cnt   = '0;
                n_state = ST_COUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_scan       <= '0;
            r_pend       <= 1'b0;
            r_cnt        <= '0;
            r_slot_count <= SLOT_COUNT_RST;
            r_dig        <= '0;
            r_bit        <= '0;
            r_tries      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan       <= n_scan;
            r_pend       <= n_pend;
            r_cnt        <= n_cnt;
            r_slot_count <= n_slot_count;
            r_dig        <= n_dig;
            r_bit        <= n_bit;
            r_tries      <= n_tries;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_crc      <= n_crc;
        r_base     <= n_base;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_salt     <= n_salt;
        r_res_slot <= n_res_slot;
        r_res_full <= n_res_full;
        r_out_slot <= n_out_slot;
        r_out_full <= n_out_full;
    end

    // used-slot map
    csa_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // the used count never passes the slot count once settled
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt <= n_eff))
        else $error("used count above slot count");

    // the map is written only by the clearing pass or an allocation
    a_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR || r_state == ST_CHECK))
        else $error("stray map write");

    // a probe that finds a free slot marks it used
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && !mem_rdata) |-> (mem_we && mem_wdata))
        else $error("free slot not marked");

    // an allocated slot lies below the slot count
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_rem < n_eff))
        else $error("hash remainder out of range");

    // a full result carries slot zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
        else $error("full result with nonzero slot");

endmodule

@@ verif/tb_crc_hashed_slot_allocator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_crc_hashed_slot_allocator: self-checking bench of the crc slot allocator
// requests are hashed by a local model of the salted crc search; every
// result beat is checked against the oldest prediction, over several
// slot_count settings, a full-fill phase and random bursty traffic
// ---------------------------------------------------------------------------
module tb_crc_hashed_slot_allocator;
    import csa_pkg::*;

    localparam int SLOT_SPACE  = 4096;     // SLOTS of the block under test
    localparam int SALT_TRIES  = 65280;    // tries in one salt period
    localparam int ITEM_TARGET = 1400;     // request beats to send in total
    localparam int IDLE_LIMIT  = 6000000;  // cycles with no beat or register write
    localparam int FILL_COUNT  = 320;      // slot_count of the fill phase

    // receiver behavior between long hold-offs
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_CHOPPY,
        RX_SLOW
    } t_rx_mode;

    typedef struct {
        logic [15:0] app_id;
        logic [15:0] entry_index;
        logic [11:0] slot;
        logic        full_res;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [15:0] app_id, [31:16] entry_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [11:0] slot, [15:12] zero
    logic        m_axis_tuser;         // [0] full_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the allocator state
    bit          slot_taken [SLOT_SPACE];
    logic [12:0] cfg_slot_count = SLOT_COUNT_RST;

    logic [31:0] req_q [$];            // request beats not yet offered
    t_grant      grant_q [$];          // predicted results, oldest first

    int          items_queued = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;

    // sender burst shaping
    int          burst_left = 0;
    int          gap_left = 0;

    // receiver stall shaping
    t_rx_mode    rx_mode = RX_STREAM;
    int          mode_left = 0;
    int          hold_left = 0;

    int          idle_cycles = 0;

    crc_hashed_slot_allocator #(
        .SLOTS(SLOT_SPACE)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // reflected crc-32 over six bytes, first byte in the low bits
    function automatic logic [31:0] salted_crc(input logic [47:0] msg);
        logic [31:0] c;
        logic        fb;
        c = CRC_INIT;
        for (int k = 0; k < 48; k++) begin
            fb = c[0] ^ msg[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return ~c;
    endfunction

    // zero acts as one slot, anything past the map saturates
    function automatic int live_slots(input logic [12:0] count);
        if (count == 0) begin
            return 1;
        end
        if (count > SLOT_SPACE) begin
            return SLOT_SPACE;
        end
        return int'(count);
    endfunction

    function automatic int count_free(input int n);
        int free_slots;
        free_slots = 0;
        for (int i = 0; i < n; i++) begin
            if (!slot_taken[i]) begin
                free_slots++;
            end
        end
        return free_slots;
    endfunction

    // walk the salt sequence until a free slot turns up, then claim it
    function automatic void claim_slot(input logic [15:0] app, input logic [15:0] ent);
        t_grant      g;
        int          n;
        int          tries;
        int          s;
        logic [7:0]  salt_lo;
        logic [7:0]  salt_hi;
        logic [31:0] h;
        bit          found;
        g.app_id      = app;
        g.entry_index = ent;
        g.slot        = '0;
        g.full_res    = 1'b1;
        n       = live_slots(cfg_slot_count);
        salt_lo = '0;
        salt_hi = '0;
        tries   = 0;
        found   = 1'b0;
        // with no free slot below the count the search is skipped
        if (count_free(n) != 0) begin
            while (!found && tries < SALT_TRIES) begin
                h = salted_crc({salt_hi, salt_lo, ent, app});
                s = int'(h[15:0]) % n;
                if (salt_lo == SALT_LOW_LAST) begin
                    salt_lo = '0;
                    salt_hi = salt_hi + 8'd1;
                end else begin
                    salt_lo = salt_lo + 8'd1;
                end
                if (!slot_taken[s]) begin
                    slot_taken[s] = 1'b1;
                    g.slot     = s[11:0];
                    g.full_res = 1'b0;
                    found      = 1'b1;
                end
                tries++;
            end
        end
        grant_q.push_back(g);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // predict at the beat itself, so slot_count is the one in force
            if (s_axis_tvalid && s_axis_tready) begin
                claim_slot(s_axis_tdata[15:0], s_axis_tdata[31:16]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    s_axis_tdata  <= req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of the bursts run straight on
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (grant_q.size() == 0) begin
                    report_mismatch($sformatf("result beat slot=%0d full=%0b with no request open",
                                              m_axis_tdata[11:0], m_axis_tuser));
                end else begin
                    if (m_axis_tuser !== grant_q[0].full_res) begin
                        report_mismatch($sformatf("app=%h ent=%h full=%0b, predicted %0b",
                                                  grant_q[0].app_id, grant_q[0].entry_index,
                                                  m_axis_tuser, grant_q[0].full_res));
                    end
                    if (m_axis_tdata[11:0] !== grant_q[0].slot) begin
                        report_mismatch($sformatf("app=%h ent=%h slot=%0d, predicted %0d",
                                                  grant_q[0].app_id, grant_q[0].entry_index,
                                                  m_axis_tdata[11:0], grant_q[0].slot));
                    end
                    if (m_axis_tdata[15:12] !== 4'h0) begin
                        report_mismatch($sformatf("app=%h ent=%h pad bits %h not zero",
                                                  grant_q[0].app_id, grant_q[0].entry_index,
                                                  m_axis_tdata[15:12]));
                    end
                    void'(grant_q.pop_front());
                end
                // two long hold-offs so the block backs up and stalls its input
                if (results_seen == 150 || results_seen == 900) begin
                    hold_left = 600;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left <= 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(1, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_STREAM: begin
                        m_axis_tready <= 1'b1;
                    end
                    RX_CHOPPY: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any beat or register write counts as progress
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // setup cycle, then access cycle; the write lands on the access edge
    task automatic write_slot_count(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SLOT_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_slot_count = value[12:0];
        @(negedge i_clk);
    endtask

    task automatic push_request(input logic [15:0] app, input logic [15:0] ent);
        req_q.push_back({ent, app});
        items_queued++;
    endtask

    // nothing queued, nothing offered, nothing predicted still open
    task automatic wait_drained();
        while (req_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // field values lean toward the extremes, single set bits and single clear bits
    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001 << $urandom_range(0, 15);
            3: return ~(16'h0001 << $urandom_range(0, 15));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial begin
        logic [31:0] wr;
        logic [15:0] last_app;
        logic [15:0] last_ent;
        int          n_eff;
        int          cap;
        int          batch;
        int          attempts;

        last_app = '0;
        last_ent = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset count: field extremes, then the same request twice to force a rehash
        push_request(16'h0000, 16'h0000);
        push_request(16'hFFFF, 16'hFFFF);
        push_request(16'hFFFF, 16'h0000);
        push_request(16'h0000, 16'hFFFF);
        push_request(16'h0001, 16'h8000);
        push_request(16'h8000, 16'h0001);
        push_request(16'h5555, 16'hAAAA);
        push_request(16'hAAAA, 16'h5555);
        push_request(16'h1234, 16'h5678);
        push_request(16'h1234, 16'h5678);
        wait_drained();

        // a zero count behaves as one slot: slot 0 or full, then full
        write_slot_count(32'd0);
        push_request(16'h00FF, 16'hFF00);
        push_request(16'hFF00, 16'h00FF);
        push_request(16'h0F0F, 16'hF0F0);
        wait_drained();

        write_slot_count(32'd1);
        push_request(16'h0000, 16'h0000);
        wait_drained();

        write_slot_count(32'd2);
        push_request(16'h0002, 16'h0003);
        push_request(16'h0004, 16'h0005);
        push_request(16'h0006, 16'h0007);
        wait_drained();

        // all ones: upper bits dropped, 8191 saturates to the full map
        write_slot_count(32'hFFFF_FFFF);
        push_request(16'hFFFF, 16'hFFFF);
        push_request(16'h7FFF, 16'h7FFF);
        push_request(16'hFFFE, 16'h0001);
        push_request(16'hC3C3, 16'h3C3C);
        wait_drained();

        // fill every slot below the count; the last ones need long salt runs,
        // the low salt byte wraps, and the closing requests come back full
        write_slot_count(FILL_COUNT);
        batch = count_free(FILL_COUNT) + 3;
        for (int i = 0; i < batch; i++) begin
            push_request(pick_field(), pick_field());
        end
        wait_drained();

        // random phases, each under its own slot_count
        while (items_queued < ITEM_TARGET) begin
            cap      = 0;
            attempts = 0;
            while (cap <= 0) begin
                attempts++;
                case ((attempts > 8) ? 9 : $urandom_range(0, 9))
                    0: wr = 32'd0;
                    1: wr = 32'd1;
                    2: wr = 32'd8191;
                    3, 4: wr = $urandom_range(2, 64);
                    5, 6: wr = $urandom_range(65, 2048);
                    default: wr = SLOT_SPACE;
                endcase
                n_eff = live_slots(wr[12:0]);
                // small counts may fill up and answer full; larger ones stay
                // at most half used so the salt search stays short
                if (n_eff <= 64) begin
                    cap = count_free(n_eff) + $urandom_range(1, 4);
                end else begin
                    cap = count_free(n_eff) - n_eff / 2;
                end
            end
            batch = $urandom_range(10, 120);
            if (batch > cap) begin
                batch = cap;
            end
            if (batch > ITEM_TARGET - items_queued) begin
                batch = ITEM_TARGET - items_queued;
            end
            write_slot_count(wr);
            for (int i = 0; i < batch; i++) begin
                // repeated pairs collide with their own earlier claim
                if ($urandom_range(0, 7) != 0) begin
                    last_app = pick_field();
                    last_ent = pick_field();
                end
                push_request(last_app, last_ent);
            end
            wait_drained();
        end

        // room for a stray beat after the last result
        repeat (100) @(posedge i_clk);
        if (grant_q.size() != 0) begin
            report_mismatch($sformatf("%0d predicted results never came", grant_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
